// ===== rtl/core/pixel_readout_word_decoder_defines.svh =====
// Assertion macros shared by the readout word decoder checkers.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef PIXEL_READOUT_WORD_DECODER_DEFINES_SVH
`define PIXEL_READOUT_WORD_DECODER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PRWD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define PRWD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/prwd_pkg.sv =====
// Shared types, codes and field layout of the pixel readout word decoder.
// No dependencies; every module of the block imports this package.
package prwd_pkg;

	// Service counter store.
	localparam int SERVICE_CODES      = 64;
	localparam int CODE_W             = $clog2(SERVICE_CODES);
	localparam int SR_COUNT_WIDTH_DEF = 32;

	// Result kinds.
	localparam logic [1:0] KIND_EVENT   = 2'd0;
	localparam logic [1:0] KIND_HIT     = 2'd1;
	localparam logic [1:0] KIND_SERVICE = 2'd2;
	localparam logic [1:0] KIND_OOB_ERR = 2'd3;

	// Boundary marks, nested: session implies container implies chunk.
	localparam logic [1:0] BND_NONE      = 2'd0;
	localparam logic [1:0] BND_CHUNK     = 2'd1;
	localparam logic [1:0] BND_CONTAINER = 2'd2;
	localparam logic [1:0] BND_SESSION   = 2'd3;

	// Word types and record headers.
	localparam logic [1:0] TYPE_RECORD  = 2'd0;
	localparam logic [1:0] TYPE_TRIGGER = 2'd1;
	localparam logic [7:0] HDR_PIXEL    = 8'hE9;
	localparam logic [7:0] HDR_SERVICE  = 8'hEF;

	// Pixel matrix bounds.
	localparam logic [8:0] MAX_ROW = 9'd336;
	localparam logic [6:0] MAX_COL = 7'd80;

	// Configuration register indexes and reset values.
	localparam logic [0:0] CFG_HIT_DISC_MODE  = 1'b0;
	localparam logic [0:0] CFG_BAD_WORD_LIMIT = 1'b1;
	localparam logic [7:0] BAD_LIMIT_RESET    = 8'd10;
	localparam logic [7:0] BAD_COUNT_MAX      = 8'hFF;

	// Output tdata layout, lowest field first.
	localparam int ROW_W       = 9;
	localparam int TD_ROW_LSB  = 40;
	localparam int TDATA_USED  = 105;
	localparam int TDATA_W     = 112;
	localparam int TDATA_PAD   = TDATA_W - TDATA_USED;

	typedef struct packed {
		logic [1:0]       kind;
		logic [23:0]      evt_tag;
		logic [4:0]       l1id;
		logic [9:0]       bcid;
		logic             header_missing;
		logic [ROW_W-1:0] row;
		logic [6:0]       col;
		logic [4:0]       tot;
		logic [5:0]       sr_code;
		logic [31:0]      sr_total;
		logic [5:0]       channel;
	} result_t;

	// Results caused by one word: up to three, slot 0 goes out first.
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     slot;
	} res_set_t;

	typedef struct packed {
		logic [1:0] hit_disc_mode;
		logic [7:0] bad_word_limit;
	} cfg_t;

	// ToT decode tables; table select 3 behaves as table 2.
	function automatic logic [4:0] tot_decode(input logic [1:0] mode, input logic [3:0] code);
		logic [4:0] offs;
		logic [4:0] val;
		offs = (mode == 2'd0) ? 5'd1 : ((mode == 2'd1) ? 5'd2 : 5'd3);
		if (code == 4'd15) begin
			val = 5'd0;
		end else if (code == 4'd14) begin
			val = (mode == 2'd0) ? 5'd14 : 5'd1;
		end else begin
			val = 5'({1'b0, code}) + offs;
		end
		return val;
	endfunction

endpackage

// ===== rtl/core/prwd_svc_ram.sv =====
// Per-code service counter store: a synchronous RAM with a registered read,
// per-entry valid bits for the container clear, and write forwarding.
// Depends on prwd_pkg.
module prwd_svc_ram #(
	parameter int COUNT_W = prwd_pkg::SR_COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [prwd_pkg::CODE_W-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic [prwd_pkg::CODE_W-1:0] wr_addr,
	input  logic [COUNT_W-1:0]          wr_data,
	input  logic                        clear,
	output logic [COUNT_W-1:0]          rd_total
);
	import prwd_pkg::*;

	logic [COUNT_W-1:0]       mem [SERVICE_CODES];
	logic [COUNT_W-1:0]       rdata_q;
	logic [CODE_W-1:0]        raddr_q;
	logic [SERVICE_CODES-1:0] valid_q;
	logic                     fwd_vld_q;
	logic [CODE_W-1:0]        fwd_addr_q;
	logic [COUNT_W-1:0]       fwd_data_q;

	// Counter array with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	// Valid bits: a container clear drops all of them, a write sets its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clear || wr_en) begin
				valid_q <= (clear ? '0 : valid_q) |
					(wr_en ? (SERVICE_CODES'(1) << wr_addr) : '0);
			end
		end
	end

	// Last write, kept to cover a read issued on the same edge as that write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	// A cleared entry reads as zero; otherwise the newest data wins.
	always_comb begin
		if (!valid_q[raddr_q]) begin
			rd_total = '0;
		end else if (fwd_vld_q && (fwd_addr_q == raddr_q)) begin
			rd_total = fwd_data_q;
		end else begin
			rd_total = rdata_q;
		end
	end

endmodule

// ===== rtl/core/prwd_decode.sv =====
// Decode stage: holds one accepted word, applies boundary effects, updates
// the event and chunk state and builds the word's result set.
// Depends on prwd_pkg; works with prwd_svc_ram for the service counters.
module prwd_decode #(
	parameter int COUNT_W = prwd_pkg::SR_COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  prwd_pkg::cfg_t              cfg,
	input  logic                        in_accept,
	input  logic [31:0]                 in_word,
	input  logic [1:0]                  in_bnd,
	output logic                        in_ready,
	input  logic [COUNT_W-1:0]          prior_total,
	output logic                        svc_wr_en,
	output logic [prwd_pkg::CODE_W-1:0] svc_wr_addr,
	output logic [COUNT_W-1:0]          svc_wr_data,
	output logic                        svc_clear,
	output prwd_pkg::res_set_t          res_set,
	output logic                        res_valid,
	input  logic                        res_ready
);
	import prwd_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [1:0]  bnd_s1;

	logic [23:0] tag_q,  tag_n;
	logic [4:0]  l1id_q, l1id_n;
	logic [9:0]  bcid_q, bcid_n;
	logic        open_q, open_n;
	logic [7:0]  bad_q,  bad_n;
	logic        halted_q, halted_n;

	logic               fire;
	logic               skip;
	logic               svc_we;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] sum;
	logic [1:0]         n;
	logic [4:0]         d1;
	logic [4:0]         d2;
	logic               oob;
	result_t            r;
	res_set_t           res_c;

	// Word fields.
	logic [5:0] channel;
	logic [1:0] wtype;
	logic [7:0] hdr;
	logic [6:0] col;
	logic [8:0] row;

	assign channel = word_s1[31:26];
	assign wtype   = word_s1[25:24];
	assign hdr     = word_s1[23:16];
	assign col     = word_s1[23:17];
	assign row     = word_s1[16:8];
	assign oob     = (col == 7'd0) || (row == 9'd0) || (col > MAX_COL) || (row > MAX_ROW);

	// The stage moves on when its results, if any, fit into the output buffer.
	assign fire      = valid_s1 && ((res_c.count == 2'd0) || res_ready);
	assign in_ready  = !valid_s1 || fire;
	assign res_valid = valid_s1 && (res_c.count != 2'd0);
	assign res_set   = res_c;

	assign svc_wr_en   = fire && svc_we;
	assign svc_wr_addr = word_s1[15:10];
	assign svc_wr_data = sum;
	assign svc_clear   = fire && (bnd_s1 >= BND_CONTAINER);

	// Stage register for the accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_word;
			bnd_s1  <= in_bnd;
		end
	end

	// Next state and result set of the word in the stage.
	always_comb begin
		r        = '0;
		res_c    = '0;
		n        = 2'd0;
		svc_we   = 1'b0;
		d1       = tot_decode(cfg.hit_disc_mode, word_s1[7:4]);
		d2       = tot_decode(cfg.hit_disc_mode, word_s1[3:0]);
		tag_n    = (bnd_s1 == BND_SESSION) ? '0 : tag_q;
		l1id_n   = (bnd_s1 == BND_SESSION) ? '0 : l1id_q;
		bcid_n   = (bnd_s1 == BND_SESSION) ? '0 : bcid_q;
		bad_n    = (bnd_s1 == BND_SESSION) ? '0 : bad_q;
		open_n   = (bnd_s1 >= BND_CONTAINER) ? 1'b0 : open_q;
		skip     = (bnd_s1 != BND_NONE) ? 1'b0 : halted_q;
		halted_n = skip;
		base     = (bnd_s1 >= BND_CONTAINER) ? '0 : prior_total;
		sum      = base + COUNT_W'(word_s1[9:0]);
		if (!skip) begin
			case (wtype)
				TYPE_TRIGGER: begin
					tag_n = word_s1[23:0];
				end
				TYPE_RECORD: begin
					if (hdr == HDR_PIXEL) begin
						l1id_n        = word_s1[14:10];
						bcid_n        = word_s1[9:0];
						open_n        = 1'b1;
						r             = '0;
						r.kind        = KIND_EVENT;
						r.evt_tag     = tag_n;
						r.l1id        = l1id_n;
						r.bcid        = bcid_n;
						r.channel     = channel;
						res_c.slot[n] = r;
						n             = n + 2'd1;
					end else if (hdr == HDR_SERVICE) begin
						svc_we        = 1'b1;
						r             = '0;
						r.kind        = KIND_SERVICE;
						r.sr_code     = word_s1[15:10];
						r.sr_total    = 32'(sum);
						r.channel     = channel;
						res_c.slot[n] = r;
						n             = n + 2'd1;
					end else begin
						// A data record with no open event opens one itself.
						if (!open_n) begin
							open_n           = 1'b1;
							r                = '0;
							r.kind           = KIND_EVENT;
							r.l1id           = l1id_n;
							r.bcid           = bcid_n;
							r.header_missing = 1'b1;
							r.channel        = channel;
							res_c.slot[n]    = r;
							n                = n + 2'd1;
						end
						if (oob) begin
							if (bad_n != BAD_COUNT_MAX) begin
								bad_n = bad_n + 8'd1;
							end
							r             = '0;
							r.kind        = KIND_OOB_ERR;
							r.row         = row;
							r.col         = col;
							r.channel     = channel;
							res_c.slot[n] = r;
							n             = n + 2'd1;
						end else begin
							if (d1 != 5'd0) begin
								r             = '0;
								r.kind        = KIND_HIT;
								r.row         = row;
								r.col         = col;
								r.tot         = d1;
								r.channel     = channel;
								res_c.slot[n] = r;
								n             = n + 2'd1;
							end
							if (d2 != 5'd0) begin
								r             = '0;
								r.kind        = KIND_HIT;
								r.row         = 9'(row + 9'd1);
								r.col         = col;
								r.tot         = d2;
								r.channel     = channel;
								res_c.slot[n] = r;
								n             = n + 2'd1;
							end
						end
					end
				end
				default: begin
				end
			endcase
			halted_n = (bad_n > cfg.bad_word_limit);
		end
		res_c.count = n;
	end

	// Event and chunk state, updated as each word leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q    <= '0;
			l1id_q   <= '0;
			bcid_q   <= '0;
			open_q   <= 1'b0;
			bad_q    <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			tag_q    <= tag_n;
			l1id_q   <= l1id_n;
			bcid_q   <= bcid_n;
			open_q   <= open_n;
			bad_q    <= bad_n;
			halted_q <= halted_n;
		end
	end

endmodule

// ===== rtl/core/prwd_res_buf.sv =====
// Output buffer: holds the result set of one word and hands the results
// out one per cycle while out_ready is high; the last one of the set carries the last mark.
// Depends on prwd_pkg.
module prwd_res_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  prwd_pkg::res_set_t res_set,
	input  logic               res_valid,
	output logic               res_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output prwd_pkg::result_t  out_res,
	output logic               out_last
);
	import prwd_pkg::*;

	logic [1:0]    cnt_q;
	result_t [2:0] slot_q;
	logic          load;
	logic          take;

	assign out_valid = (cnt_q != 2'd0);
	assign out_last  = (cnt_q == 2'd1);
	assign out_res   = slot_q[0];
	assign take      = out_valid && out_ready;
	assign res_ready = (cnt_q == 2'd0) || (out_last && out_ready);
	assign load      = res_valid && res_ready;

	// Number of results still to go.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_set.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result slots; each taken result shifts the rest down.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res_set.slot;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// ===== rtl/core/pixel_readout_word_decoder.sv =====
// Top level of the pixel readout word decoder: input channel, config port,
// decode stage, service counter RAM and output buffer.
// Depends on prwd_pkg, prwd_svc_ram, prwd_decode and prwd_res_buf.
//
// Use: readout words enter on the s_ channel (tdata = raw_word, tuser =
// boundary mark). Results leave on the m_ channel: tuser is the result kind,
// tlast marks the last result caused by a word, tdata carries the fields.
// A word produces zero to three results.
// Path: a word accepted at a clock edge is decoded in the next cycle; its
// results are loaded into the output buffer once it has room, and that buffer drives the m_ channel.
// Throughput: one word per cycle while each word produces at most one
// result and m_tready stays high; a word with two or three results holds
// the output until all of them are taken. The rate is set by the output buffer;
// the one read-modify-write per word of the service counter RAM, read on the
// accepting edge and written back when the word leaves decode, does not limit it.
// Reset: all state clears at once; the counter RAM has per-entry valid bits,
// so there is no clearing pass and words are accepted right after reset.
// Stall: while the receiver holds m_tready low the current result holds;
// words with no results still pass, the next word with results waits in
// decode, after which s_tready drops.
// Configuration is written through cfg_we, cfg_index and cfg_data.
module pixel_readout_word_decoder #(
	parameter int SR_COUNT_WIDTH = prwd_pkg::SR_COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input channel.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,  // raw_word
	input  logic [1:0]                   s_tuser,  // boundary
	// Output channel.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// evt_tag, l1id, bcid, header_missing, row, col, tot, sr_code,
	// sr_total, channel, zero padding
	output logic [prwd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                   m_tuser,  // kind
	output logic                         m_tlast,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [7:0]                   cfg_data
);
	import prwd_pkg::*;

	cfg_t                      cfg_q;
	logic                      accept;
	logic [SR_COUNT_WIDTH-1:0] prior_total;
	logic                      svc_wr_en;
	logic [CODE_W-1:0]         svc_wr_addr;
	logic [SR_COUNT_WIDTH-1:0] svc_wr_data;
	logic                      svc_clear;
	res_set_t                  res_set;
	logic                      res_valid;
	logic                      res_ready;
	result_t                   out_res;

	assign accept = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_disc_mode  <= 2'd0;
			cfg_q.bad_word_limit <= BAD_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HIT_DISC_MODE: begin
					cfg_q.hit_disc_mode <= cfg_data[1:0];
				end
				CFG_BAD_WORD_LIMIT: begin
					cfg_q.bad_word_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Service counters, read at the code field of the accepted word.
	prwd_svc_ram #(
		.COUNT_W(SR_COUNT_WIDTH)
	) u_svc_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (s_tdata[15:10]),
		.wr_en   (svc_wr_en),
		.wr_addr (svc_wr_addr),
		.wr_data (svc_wr_data),
		.clear   (svc_clear),
		.rd_total(prior_total)
	);

	prwd_decode #(
		.COUNT_W(SR_COUNT_WIDTH)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_accept  (accept),
		.in_word    (s_tdata),
		.in_bnd     (s_tuser),
		.in_ready   (s_tready),
		.prior_total(prior_total),
		.svc_wr_en  (svc_wr_en),
		.svc_wr_addr(svc_wr_addr),
		.svc_wr_data(svc_wr_data),
		.svc_clear  (svc_clear),
		.res_set    (res_set),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	prwd_res_buf u_res_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_set  (res_set),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res),
		.out_last (m_tlast)
	);

	// Pack the result fields, lowest field first.
	assign m_tuser = out_res.kind;
	assign m_tdata = {
		{TDATA_PAD{1'b0}},
		out_res.channel,
		out_res.sr_total,
		out_res.sr_code,
		out_res.tot,
		out_res.col,
		out_res.row,
		out_res.header_missing,
		out_res.bcid,
		out_res.l1id,
		out_res.evt_tag
	};

endmodule

// ===== rtl/core/prwd_checker.sv =====
// Port-level checks on the output channel of the readout word decoder,
// bound to the top level. Depends on prwd_pkg and the defines header.
`include "pixel_readout_word_decoder_defines.svh"

module prwd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [prwd_pkg::TDATA_W-1:0] m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         m_tlast
);
	import prwd_pkg::*;

	// A stalled result holds.
	`PRWD_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// The results of one word come out without a gap.
	`PRWD_ASSERT(a_set_contig, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "gap inside a result set")

	// An event that is not last was opened by a data record: a hit or error follows.
	`PRWD_ASSERT(a_event_next, m_tvalid && m_tready && !m_tlast && (m_tuser == KIND_EVENT) |=> (m_tuser == KIND_HIT) || (m_tuser == KIND_OOB_ERR), "event not followed by hit or error")

	// A first hit that is not last is followed by the second hit one row up.
	`PRWD_ASSERT(a_hit_pair, m_tvalid && m_tready && !m_tlast && (m_tuser == KIND_HIT) |=> (m_tuser == KIND_HIT) && (m_tdata[TD_ROW_LSB +: ROW_W] == ROW_W'($past(m_tdata[TD_ROW_LSB +: ROW_W]) + 1'b1)), "second hit row mismatch")

	// Nothing is offered while reset is held.
	`PRWD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind pixel_readout_word_decoder prwd_checker u_prwd_checker (.*);
